// ===== design/spsb_pkg.sv =====
// shared types, constants and tables for the sphere patch split and bound block
// used by spsb_bound_pipe and sphere_patch_split_and_bound_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spsb_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CORDIC_STEPS  = 18;
    localparam int TABLE_LEN     = 30;
    localparam int SQRT_STEPS    = 32;

    localparam logic signed [33:0] GAIN_Q30       = 34'sd652032874;
    localparam logic [26:0]        DEG_TO_RAD_Q32 = 27'd74961321;

    localparam logic signed [35:0] DEG90  = 36'sd90 <<< FRACTION_BITS;
    localparam logic signed [35:0] DEG180 = 36'sd180 <<< FRACTION_BITS;
    localparam logic signed [35:0] DEG270 = 36'sd270 <<< FRACTION_BITS;
    localparam logic signed [35:0] DEG360 = 36'sd360 <<< FRACTION_BITS;

    localparam logic [31:0] DETAIL_LOW_RESET  = 32'd100 << FRACTION_BITS;
    localparam logic [31:0] DETAIL_HIGH_RESET = 32'hFFFF_FFFF;

    localparam logic KIND_LEAF  = 1'b0;
    localparam logic KIND_CHILD = 1'b1;

    localparam logic REG_DETAIL_LOW  = 1'b0;
    localparam logic REG_DETAIL_HIGH = 1'b1;

    typedef struct packed {
        logic               kind;
        logic               last;
        logic [30:0]        radius;
        logic signed [31:0] z_low;
        logic signed [31:0] z_high;
        logic signed [26:0] angle_a;
        logic signed [26:0] angle_b;
        logic signed [25:0] tm;
        logic signed [25:0] tx;
    } job_t;

    typedef struct packed {
        logic               kind;
        logic               last;
        logic [30:0]        radius;
        logic signed [31:0] z_low;
        logic signed [31:0] z_high;
        logic signed [26:0] angle_a;
        logic signed [26:0] angle_b;
        logic signed [31:0] bx_low;
        logic signed [31:0] bx_high;
        logic signed [31:0] by_low;
        logic signed [31:0] by_high;
    } res_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd7;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/spsb_bound_pipe.sv =====
// bounding box pipeline: distances by pipelined square root, sines and cosines by
// pipelined cordic, then scaling and saturation; depends on spsb_pkg
`timescale 1ns / 1ps
`default_nettype none

module spsb_bound_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          in_valid,
    input  spsb_pkg::job_t     in_job,
    output logic               out_valid,
    output spsb_pkg::res_t     out_res
);

    localparam int NCH = spsb_pkg::SQRT_STEPS;

    typedef struct packed {
        logic        flip;
        logic        neg;
        logic [31:0] mag;
    } prep_t;

    typedef struct packed {
        logic b0c, b0s, b1c, b2c, b2s, b3c, b3s;
    } flags_t;

    typedef struct packed {
        spsb_pkg::job_t job;
        flags_t         flags;
        logic           straddle;
        logic [31:0]    azl;
        logic [31:0]    azh;
        prep_t          pm;
        prep_t          px;
    } s1_t;

    typedef struct packed {
        spsb_pkg::job_t job;
        flags_t         flags;
        logic           straddle;
        logic           gt_lo;
        logic           gt_hi;
        logic [61:0]    sq_r;
        logic [63:0]    sq_lo;
        logic [63:0]    sq_hi;
        logic           flip_m, neg_m, flip_x, neg_x;
        logic [58:0]    rad_m;
        logic [58:0]    rad_x;
    } s2_t;

    typedef struct packed {
        spsb_pkg::job_t    job;
        flags_t            flags;
        logic              flip_m;
        logic              flip_x;
        logic [63:0]       v_max, q_max, v_min, q_min;
        logic signed [33:0] xm, ym, zm, xx, yx, zx;
    } ch_t;

    typedef struct packed {
        spsb_pkg::job_t   job;
        logic [30:0]      rmax;
        logic [3:0][30:0] rsel;
        logic [3:0][33:0] m;
        logic [3:0]       sp;
    } s4_t;

    typedef struct packed {
        spsb_pkg::job_t   job;
        logic [30:0]      rmax;
        logic [3:0]       sp;
        logic [3:0][65:0] prod;
    } s5_t;

    function automatic logic signed [35:0] ext_ang(input logic signed [25:0] t);
        return $signed({{10{t[25]}}, t});
    endfunction

    function automatic logic signed [35:0] abs36(input logic signed [35:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic prep_t prep(input logic signed [25:0] t);
        logic signed [35:0] a;
        logic signed [35:0] mg;
        prep_t              p;
        a = ext_ang(t);
        p.flip = 1'b0;
        if (a > spsb_pkg::DEG180)
            a = a - spsb_pkg::DEG360;
        else if (a <= -spsb_pkg::DEG180)
            a = a + spsb_pkg::DEG360;
        if (a > spsb_pkg::DEG90)
        begin
            a = a - spsb_pkg::DEG180;
            p.flip = 1'b1;
        end
        else if (a < -spsb_pkg::DEG90)
        begin
            a = a + spsb_pkg::DEG180;
            p.flip = 1'b1;
        end
        p.neg = (a < 0);
        mg = p.neg ? -a : a;
        p.mag = mg[31:0];
        return p;
    endfunction

    function automatic logic signed [31:0] scale(input logic signed [65:0] prod);
        logic signed [65:0] t;
        t = (prod + (66'sd1 <<< 29)) >>> 30;
        if (t > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (t < -66'sd2147483648)
            return 32'sh8000_0000;
        return t[31:0];
    endfunction

    // stage 1: magnitudes, quadrant decisions, angle wrap and fold
    s1_t s1_reg, s1_next;
    logic s1_valid_reg;

    always_comb
    begin
        logic signed [35:0] tm, tx, am, ax;
        s1_next.job = in_job;
        s1_next.straddle = (in_job.z_low < 0) && (in_job.z_high > 0);
        s1_next.azl = (in_job.z_low < 0) ? 32'(-in_job.z_low) : 32'(in_job.z_low);
        s1_next.azh = (in_job.z_high < 0) ? 32'(-in_job.z_high) : 32'(in_job.z_high);
        s1_next.pm = prep(in_job.tm);
        s1_next.px = prep(in_job.tx);
        tm = ext_ang(in_job.tm);
        tx = ext_ang(in_job.tx);
        am = abs36(tm);
        ax = abs36(tx);
        s1_next.flags.b0c = (ax > spsb_pkg::DEG90) && (am < spsb_pkg::DEG270);
        s1_next.flags.b0s = (ax < spsb_pkg::DEG180) || (am > spsb_pkg::DEG180);
        s1_next.flags.b1c = (am < spsb_pkg::DEG90) || (ax > spsb_pkg::DEG270);
        am = abs36(spsb_pkg::DEG90 - tm);
        ax = abs36(spsb_pkg::DEG90 - tx);
        s1_next.flags.b2c = (ax > spsb_pkg::DEG90) && (am < spsb_pkg::DEG270);
        s1_next.flags.b2s = (ax < spsb_pkg::DEG180) || (am > spsb_pkg::DEG180);
        am = abs36(spsb_pkg::DEG90 + tm);
        ax = abs36(spsb_pkg::DEG90 + tx);
        s1_next.flags.b3c = (ax > spsb_pkg::DEG90) && (am < spsb_pkg::DEG270);
        s1_next.flags.b3s = (ax < spsb_pkg::DEG180) || (am > spsb_pkg::DEG180);
    end

    // stage 2: squares and degree to radian products
    s2_t s2_reg, s2_next;
    logic s2_valid_reg;

    always_comb
    begin
        logic [31:0] zmin, zmax;
        zmin = (s1_reg.azl < s1_reg.azh) ? s1_reg.azl : s1_reg.azh;
        zmax = (s1_reg.azl > s1_reg.azh) ? s1_reg.azl : s1_reg.azh;
        s2_next.job = s1_reg.job;
        s2_next.flags = s1_reg.flags;
        s2_next.straddle = s1_reg.straddle;
        s2_next.gt_lo = {1'b0, s1_reg.job.radius} > zmin;
        s2_next.gt_hi = {1'b0, s1_reg.job.radius} > zmax;
        s2_next.sq_r = 62'(s1_reg.job.radius) * 62'(s1_reg.job.radius);
        s2_next.sq_lo = 64'(zmin) * 64'(zmin);
        s2_next.sq_hi = 64'(zmax) * 64'(zmax);
        s2_next.flip_m = s1_reg.pm.flip;
        s2_next.neg_m = s1_reg.pm.neg;
        s2_next.flip_x = s1_reg.px.flip;
        s2_next.neg_x = s1_reg.px.neg;
        s2_next.rad_m = 59'(s1_reg.pm.mag) * 59'(spsb_pkg::DEG_TO_RAD_Q32);
        s2_next.rad_x = 59'(s1_reg.px.mag) * 59'(spsb_pkg::DEG_TO_RAD_Q32);
    end

    // stage 3: square root arguments and cordic start values
    ch_t ch_reg [NCH+1];
    ch_t ch_next [NCH+1];
    logic [NCH:0] ch_valid_reg;

    always_comb
    begin
        logic signed [33:0] zm, zx;
        zm = $signed(34'(s2_reg.rad_m >> (spsb_pkg::FRACTION_BITS + 2)));
        zx = $signed(34'(s2_reg.rad_x >> (spsb_pkg::FRACTION_BITS + 2)));
        ch_next[0].job = s2_reg.job;
        ch_next[0].flags = s2_reg.flags;
        ch_next[0].flip_m = s2_reg.flip_m;
        ch_next[0].flip_x = s2_reg.flip_x;
        if (s2_reg.straddle)
            ch_next[0].v_max = 64'(s2_reg.sq_r);
        else if (s2_reg.gt_lo)
            ch_next[0].v_max = 64'(s2_reg.sq_r) - s2_reg.sq_lo;
        else
            ch_next[0].v_max = 64'd0;
        ch_next[0].v_min = s2_reg.gt_hi ? 64'(s2_reg.sq_r) - s2_reg.sq_hi : 64'd0;
        ch_next[0].q_max = 64'd0;
        ch_next[0].q_min = 64'd0;
        ch_next[0].xm = spsb_pkg::GAIN_Q30;
        ch_next[0].ym = 34'sd0;
        ch_next[0].zm = s2_reg.neg_m ? -zm : zm;
        ch_next[0].xx = spsb_pkg::GAIN_Q30;
        ch_next[0].yx = 34'sd0;
        ch_next[0].zx = s2_reg.neg_x ? -zx : zx;
    end

    // chain: one square root step per stage, and one cordic rotation in each stage below CORDIC_STEPS
    for (genvar k = 0; k < NCH; k++)
    begin : g_chain
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        localparam logic signed [33:0] ATAN = $signed({2'b00, spsb_pkg::atan_q30(k)});
        localparam bit ROTATE = (k < spsb_pkg::CORDIC_STEPS) && (k < spsb_pkg::TABLE_LEN);

        always_comb
        begin
            logic [63:0] tb;
            ch_next[k+1] = ch_reg[k];
            tb = ch_reg[k].q_max + SQ_BIT;
            if (ch_reg[k].v_max >= tb)
            begin
                ch_next[k+1].v_max = ch_reg[k].v_max - tb;
                ch_next[k+1].q_max = (ch_reg[k].q_max >> 1) + SQ_BIT;
            end
            else
                ch_next[k+1].q_max = ch_reg[k].q_max >> 1;
            tb = ch_reg[k].q_min + SQ_BIT;
            if (ch_reg[k].v_min >= tb)
            begin
                ch_next[k+1].v_min = ch_reg[k].v_min - tb;
                ch_next[k+1].q_min = (ch_reg[k].q_min >> 1) + SQ_BIT;
            end
            else
                ch_next[k+1].q_min = ch_reg[k].q_min >> 1;
            if (ROTATE)
            begin
                if (ch_reg[k].zm >= 0)
                begin
                    ch_next[k+1].xm = ch_reg[k].xm - (ch_reg[k].ym >>> k);
                    ch_next[k+1].ym = ch_reg[k].ym + (ch_reg[k].xm >>> k);
                    ch_next[k+1].zm = ch_reg[k].zm - ATAN;
                end
                else
                begin
                    ch_next[k+1].xm = ch_reg[k].xm + (ch_reg[k].ym >>> k);
                    ch_next[k+1].ym = ch_reg[k].ym - (ch_reg[k].xm >>> k);
                    ch_next[k+1].zm = ch_reg[k].zm + ATAN;
                end
                if (ch_reg[k].zx >= 0)
                begin
                    ch_next[k+1].xx = ch_reg[k].xx - (ch_reg[k].yx >>> k);
                    ch_next[k+1].yx = ch_reg[k].yx + (ch_reg[k].xx >>> k);
                    ch_next[k+1].zx = ch_reg[k].zx - ATAN;
                end
                else
                begin
                    ch_next[k+1].xx = ch_reg[k].xx + (ch_reg[k].yx >>> k);
                    ch_next[k+1].yx = ch_reg[k].yx - (ch_reg[k].xx >>> k);
                    ch_next[k+1].zx = ch_reg[k].zx + ATAN;
                end
            end
        end
    end

    // stage 4: sign flips, extreme sines and cosines, distance selection
    s4_t s4_reg, s4_next;
    logic s4_valid_reg;

    always_comb
    begin
        logic signed [33:0] ctm, stm, ctx, stx;
        logic [30:0]        rmax, rmin;
        ch_t                c;
        c = ch_reg[NCH];
        ctm = c.flip_m ? -c.xm : c.xm;
        stm = c.flip_m ? -c.ym : c.ym;
        ctx = c.flip_x ? -c.xx : c.xx;
        stx = c.flip_x ? -c.yx : c.yx;
        rmax = c.q_max[30:0];
        rmin = c.q_min[30:0];
        s4_next.job = c.job;
        s4_next.rmax = rmax;
        s4_next.m[0] = (ctx < ctm) ? ctx : ctm;
        s4_next.m[1] = (ctx > ctm) ? ctx : ctm;
        s4_next.m[2] = (stx < stm) ? stx : stm;
        s4_next.m[3] = (stx > stm) ? stx : stm;
        s4_next.rsel[0] = c.flags.b0c ? rmax : rmin;
        s4_next.rsel[1] = c.flags.b1c ? rmax : rmin;
        s4_next.rsel[2] = c.flags.b2c ? rmax : rmin;
        s4_next.rsel[3] = c.flags.b3c ? rmax : rmin;
        s4_next.sp[0] = c.flags.b0c && !c.flags.b0s;
        s4_next.sp[1] = 1'b0;
        s4_next.sp[2] = c.flags.b2c && !c.flags.b2s;
        s4_next.sp[3] = c.flags.b3c && !c.flags.b3s;
    end

    // stage 5: distance times sine or cosine
    s5_t s5_reg, s5_next;
    logic s5_valid_reg;

    always_comb
    begin
        s5_next.job = s4_reg.job;
        s5_next.rmax = s4_reg.rmax;
        s5_next.sp = s4_reg.sp;
        for (int i = 0; i < 4; i++)
            s5_next.prod[i] = 66'($signed({1'b0, s4_reg.rsel[i]}) * $signed(s4_reg.m[i]));
    end

    // stage 6: rounding, saturation, result register
    spsb_pkg::res_t res_reg, res_next;
    logic res_valid_reg;

    always_comb
    begin
        logic signed [31:0] b [4];
        logic signed [31:0] rm;
        rm = $signed({1'b0, s5_reg.rmax});
        for (int i = 0; i < 4; i++)
            b[i] = scale(s5_reg.prod[i]);
        if (s5_reg.sp[0])
            b[0] = -rm;
        if (s5_reg.sp[2])
            b[2] = -rm;
        if (s5_reg.sp[3])
            b[3] = rm;
        if (s5_reg.job.kind == spsb_pkg::KIND_LEAF)
            for (int i = 0; i < 4; i++)
                b[i] = 32'sd0;
        res_next.kind = s5_reg.job.kind;
        res_next.last = s5_reg.job.last;
        res_next.radius = s5_reg.job.radius;
        res_next.z_low = s5_reg.job.z_low;
        res_next.z_high = s5_reg.job.z_high;
        res_next.angle_a = s5_reg.job.angle_a;
        res_next.angle_b = s5_reg.job.angle_b;
        res_next.bx_low = b[0];
        res_next.bx_high = b[1];
        res_next.by_low = b[2];
        res_next.by_high = b[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ch_valid_reg <= '0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            ch_valid_reg <= {ch_valid_reg[NCH-1:0], s2_valid_reg};
            s4_valid_reg <= ch_valid_reg[NCH];
            s5_valid_reg <= s4_valid_reg;
            res_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            for (int i = 0; i <= NCH; i++)
                ch_reg[i] <= ch_next[i];
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== design/sphere_patch_split_and_bound_core.sv =====
// top level of the sphere patch split and bound block: input holding, child issue,
// detail limit registers and the result stream; depends on spsb_pkg, spsb_bound_pipe
// a patch passes the issue register and the bounding pipeline registers in order
// before its first result reaches the output; a splitting patch issues its children
// one at a time through the single issue port into the pipeline; a leaf issues one job
// the pipeline stalls as a whole while a result waits at the output
// reset clears valid bits, the issue counter and the limits (100.0 and all ones)
`timescale 1ns / 1ps
`default_nettype none

module sphere_patch_split_and_bound_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // patch in: radius[30:0] z_low[62:31] z_high[94:63] angle_low[120:95]
    // angle_high[146:121] detail_level[178:147], zero fill above
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [183:0] s_axis_tdata,
    // result out: out_radius[30:0] out_z_low[62:31] out_z_high[94:63]
    // out_angle_a[121:95] out_angle_b[148:122] bound_x_low[180:149]
    // bound_x_high[212:181] bound_y_low[244:213] bound_y_high[276:245], zero fill
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [279:0]      m_axis_tdata,
    // result_kind[0]
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    // limit register writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);

    // detail limits
    logic [31:0] detail_low_reg, detail_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detail_low_reg  <= spsb_pkg::DETAIL_LOW_RESET;
            detail_high_reg <= spsb_pkg::DETAIL_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spsb_pkg::REG_DETAIL_LOW:  detail_low_reg  <= cfg_data;
                spsb_pkg::REG_DETAIL_HIGH: detail_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input field unpacking
    logic [30:0]        in_radius;
    logic signed [31:0] in_z_low, in_z_high;
    logic signed [25:0] in_angle_low, in_angle_high;
    logic [31:0]        in_detail;

    assign in_radius     = s_axis_tdata[30:0];
    assign in_z_low      = $signed(s_axis_tdata[62:31]);
    assign in_z_high     = $signed(s_axis_tdata[94:63]);
    assign in_angle_low  = $signed(s_axis_tdata[120:95]);
    assign in_angle_high = $signed(s_axis_tdata[146:121]);
    assign in_detail     = s_axis_tdata[178:147];

    // held patch and child counter
    logic               item_valid_reg;
    logic               leaf_reg;
    logic [1:0]         cnt_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] z_low_reg, z_high_reg;
    logic signed [25:0] a_low_reg, a_high_reg;

    // whole pipeline moves when the output slot is empty or being emptied
    logic advance;
    assign advance = !m_axis_tvalid || m_axis_tready;

    // job for the current child, or the leaf
    spsb_pkg::job_t     cur_job;
    logic signed [32:0] z_sum;
    logic signed [26:0] a_sum;
    logic signed [31:0] z_mid;
    logic signed [25:0] a_mid;

    always_comb
    begin
        z_sum = 33'(z_low_reg) + 33'(z_high_reg);
        a_sum = 27'(a_low_reg) + 27'(a_high_reg);
        z_mid = z_sum[32:1];
        a_mid = a_sum[26:1];
        cur_job.radius = radius_reg;
        if (leaf_reg)
        begin
            cur_job.kind    = spsb_pkg::KIND_LEAF;
            cur_job.last    = 1'b1;
            cur_job.z_low   = z_low_reg;
            cur_job.z_high  = z_high_reg;
            cur_job.angle_a = 27'(a_low_reg);
            cur_job.angle_b = 27'(a_high_reg) - 27'(a_low_reg);
            cur_job.tm      = a_low_reg;
            cur_job.tx      = a_high_reg;
        end
        else
        begin
            // order: low z low angle, high z low angle, low z high angle, high z high angle
            cur_job.kind    = spsb_pkg::KIND_CHILD;
            cur_job.last    = (cnt_reg == 2'd3);
            cur_job.z_low   = cnt_reg[0] ? z_mid : z_low_reg;
            cur_job.z_high  = cnt_reg[0] ? z_high_reg : z_mid;
            cur_job.tm      = cnt_reg[1] ? a_mid : a_low_reg;
            cur_job.tx      = cnt_reg[1] ? a_high_reg : a_mid;
            cur_job.angle_a = 27'(cur_job.tm);
            cur_job.angle_b = 27'(cur_job.tx);
        end
    end

    // next patch is taken as the last job of this one issues
    assign s_axis_tready = !item_valid_reg || (advance && cur_job.last);

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else if (in_xfer)
        begin
            item_valid_reg <= 1'b1;
            cnt_reg        <= 2'd0;
        end
        else if (advance && item_valid_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cur_job.last)
                item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            leaf_reg   <= (in_detail < detail_low_reg) || (in_detail > detail_high_reg);
            radius_reg <= in_radius;
            z_low_reg  <= in_z_low;
            z_high_reg <= in_z_high;
            a_low_reg  <= in_angle_low;
            a_high_reg <= in_angle_high;
        end
    end

    // issue register in front of the pipeline
    spsb_pkg::job_t job_reg;
    logic           job_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else if (advance)
            job_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            job_reg <= cur_job;
    end

    // distances, cordic and scaling
    spsb_pkg::res_t res;
    logic           res_valid;

    spsb_bound_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (job_valid_reg),
        .in_job    (job_reg),
        .out_valid (res_valid),
        .out_res   (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res.kind;
    assign m_axis_tlast  = res.last;
    assign m_axis_tdata  = {3'b000, res.by_high, res.by_low, res.bx_high, res.bx_low,
                            res.angle_b, res.angle_a, res.z_high, res.z_low, res.radius};

    // a leaf always closes its run
    a_leaf_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spsb_pkg::KIND_LEAF) |-> m_axis_tlast)
        else $error("leaf result without tlast");

    // a leaf carries an empty box
    a_leaf_box: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spsb_pkg::KIND_LEAF)
        |-> (m_axis_tdata[276:149] == '0))
        else $error("leaf result with non-zero bounds");

    // an accepted patch is held for issue
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> item_valid_reg && (cnt_reg == 2'd0))
        else $error("accepted patch not held");

    // a stalled issue register keeps its job
    a_issue_stall: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !advance |=> job_valid_reg && $stable(job_reg))
        else $error("issue register changed during stall");

endmodule

`default_nettype wire
